// ----- src/spq_pkg.sv -----
// Shared types, codes and field layout for the stable priority queue.
package spq_pkg;

  // Field widths of one input beat and one result beat
  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int PRIO_W   = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  // Input tdata layout, lowest bit first
  localparam int CMD_LSB   = 0;
  localparam int VALUE_LSB = CMD_LSB + CMD_W;
  localparam int PRIO_LSB  = VALUE_LSB + VALUE_W;
  localparam int IN_USED_W = PRIO_LSB + PRIO_W;
  localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata layout, lowest bit first
  localparam int FRONT_LSB  = 0;
  localparam int STATUS_LSB = FRONT_LSB + VALUE_W;
  localparam int TOTAL_LSB  = STATUS_LSB + STATUS_W;
  localparam int LEVELS_LSB = TOTAL_LSB + COUNT_W;
  localparam int LVLCNT_LSB = LEVELS_LSB + COUNT_W;
  localparam int OUT_USED_W = LVLCNT_LSB + COUNT_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    PH_IDLE  = 1'b0,
    PH_APPLY = 1'b1
  } phase_e;

  // Shift command broadcast to every cell of the row
  typedef struct packed {
    logic enq;  // open a gap at the insertion point, shift the tail right
    logic deq;  // drop the front, shift everything left
  } cell_op_t;

endpackage

// ----- src/spq_cell.sv -----
// One cell of the sorted row: holds one entry and trades it with its neighbors.
module spq_cell #(
  parameter int LVL_W      = 8,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  spq_pkg::cell_op_t     op_i,
  input  logic [LVL_W-1:0]      new_prio_i,
  input  logic [VALUE_BITS-1:0] new_value_i,
  input  logic                  left_ins_i,
  input  logic                  left_valid_i,
  input  logic [LVL_W-1:0]      left_prio_i,
  input  logic [VALUE_BITS-1:0] left_value_i,
  input  logic                  right_valid_i,
  input  logic [LVL_W-1:0]      right_prio_i,
  input  logic [VALUE_BITS-1:0] right_value_i,
  output logic                  ins_o,
  output logic                  valid_o,
  output logic [LVL_W-1:0]      prio_o,
  output logic [VALUE_BITS-1:0] value_o
);
  import spq_pkg::*;

  logic                  valid_q, valid_d;
  logic [LVL_W-1:0]      prio_q, prio_d;
  logic [VALUE_BITS-1:0] value_q, value_d;

  // New entry belongs at or before this cell; equal levels stay ahead (FIFO order)
  assign ins_o = !valid_q || (prio_q > new_prio_i);

  always_comb begin
    valid_d = valid_q;
    prio_d  = prio_q;
    value_d = value_q;
    if (op_i.deq) begin
      valid_d = right_valid_i;
      prio_d  = right_prio_i;
      value_d = right_value_i;
    end else if (op_i.enq) begin
      if (left_ins_i) begin
        valid_d = left_valid_i;
        prio_d  = left_prio_i;
        value_d = left_value_i;
      end else if (ins_o) begin
        valid_d = 1'b1;
        prio_d  = new_prio_i;
        value_d = new_value_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q  <= prio_d;
    value_q <= value_d;
  end

  assign valid_o = valid_q;
  assign prio_o  = prio_q;
  assign value_o = value_q;

endmodule

// ----- src/spq_level_table.sv -----
// Per-level value counts: one write port, two registered read ports.
module spq_level_table #(
  parameter int PRIORITY_LEVELS = 256,
  parameter int CNT_W           = 9,
  localparam int LVL_W          = $clog2(PRIORITY_LEVELS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [LVL_W-1:0] rd_a_addr_i,
  input  logic [LVL_W-1:0] rd_b_addr_i,
  output logic [CNT_W-1:0] rd_a_data_o,
  output logic [CNT_W-1:0] rd_b_data_o,
  input  logic             wr_en_i,
  input  logic [LVL_W-1:0] wr_addr_i,
  input  logic [CNT_W-1:0] wr_data_i
);
  import spq_pkg::*;

  logic [CNT_W-1:0]           mem_q [PRIORITY_LEVELS];
  logic [PRIORITY_LEVELS-1:0] written_q;
  logic [CNT_W-1:0]           rd_a_q, rd_b_q;

  // Entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (wr_en_i) begin
      written_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q <= written_q[rd_a_addr_i] ? mem_q[rd_a_addr_i] : '0;
      rd_b_q <= written_q[rd_b_addr_i] ? mem_q[rd_b_addr_i] : '0;
    end
  end

  assign rd_a_data_o = rd_a_q;
  assign rd_b_data_o = rd_b_q;

endmodule

// ----- src/stable_priority_queue_core.sv -----
// Stable priority queue core: sorted row of cells plus per-level count table.
//
// Usage:
//   Input beats on s_axis carry a command (enqueue, dequeue, peek), a value
//   word and a priority. Lower priority numbers are served first; values of
//   equal priority leave in arrival order. Priorities above the top level are
//   saturated to the top level. Command code 3 behaves as peek.
//   Every input beat yields exactly one result beat on m_axis: front value,
//   status (ok, empty, full), total count, non-empty level count and the
//   count held at the beat's priority.
//   Steps: an accepted beat is registered and the per-level count table is
//   read; the apply step then shifts the cell row, writes the table and
//   loads the result register, which drives m_axis. s_axis stays not ready
//   until the item is committed, so one item is handled at a time.
//   Stall: a result waiting on m_axis does not block the next input beat; the
//   apply step of that next item holds until the result register frees.
//   Reset: the queue comes up empty and takes input on the first cycle after
//   reset release; no clearing pass is needed.
module stable_priority_queue_core #(
  parameter int CAPACITY        = 256,
  parameter int PRIORITY_LEVELS = 256,
  parameter int VALUE_BITS      = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // command[1:0], item_value[33:2], item_priority[41:34], zero fill
  input  logic [spq_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // front_value[31:0], status[33:32], total_count[42:34],
  // levels_in_use[51:43], level_count[60:52], zero fill
  output logic [spq_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);
  import spq_pkg::*;

  localparam int LVL_W  = $clog2(PRIORITY_LEVELS);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int LVLS_W = $clog2(PRIORITY_LEVELS + 1);

  // ---------------------------------------------------------------------------
  // Sequencer: idle (take a beat) and apply (commit the item)
  // ---------------------------------------------------------------------------
  phase_e phase_q, phase_d;
  logic   in_accept;
  logic   finish;
  logic   out_valid_q, out_valid_d;

  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  // Commit only when the result register is free or draining this cycle
  assign finish = (phase_q == PH_APPLY) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_IDLE:  if (in_accept) phase_d = PH_APPLY;
      PH_APPLY: if (finish)    phase_d = PH_IDLE;
      default:  phase_d = PH_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = (phase_q == PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Input capture
  // ---------------------------------------------------------------------------
  logic [CMD_W-1:0]      in_cmd;
  logic [VALUE_W-1:0]    in_value;
  logic [PRIO_W-1:0]     in_prio;
  logic [LVL_W-1:0]      in_lvl;
  logic [CMD_W-1:0]      cmd_q;
  logic [VALUE_BITS-1:0] value_q;
  logic [LVL_W-1:0]      lvl_q;

  assign in_cmd   = s_axis_tdata_i[CMD_LSB +: CMD_W];
  assign in_value = s_axis_tdata_i[VALUE_LSB +: VALUE_W];
  assign in_prio  = s_axis_tdata_i[PRIO_LSB +: PRIO_W];

  // Saturate priorities above the top level
  always_comb begin
    if (32'(in_prio) >= 32'(PRIORITY_LEVELS)) begin
      in_lvl = LVL_W'(PRIORITY_LEVELS - 1);
    end else begin
      in_lvl = LVL_W'(in_prio);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q   <= in_cmd;
      value_q <= VALUE_BITS'(in_value);
      lvl_q   <= in_lvl;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell row: entries sorted by level, oldest first within a level
  // ---------------------------------------------------------------------------
  cell_op_t              cell_op;
  logic [CAPACITY-1:0]   cell_ins;
  logic [CAPACITY-1:0]   cell_valid;
  logic [LVL_W-1:0]      cell_prio  [CAPACITY];
  logic [VALUE_BITS-1:0] cell_value [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  l_ins, l_valid, r_valid;
    logic [LVL_W-1:0]      l_prio, r_prio;
    logic [VALUE_BITS-1:0] l_value, r_value;

    if (i == 0) begin : g_head
      assign l_ins   = 1'b0;
      assign l_valid = 1'b0;
      assign l_prio  = '0;
      assign l_value = '0;
    end else begin : g_link_left
      assign l_ins   = cell_ins[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_prio  = cell_prio[i-1];
      assign l_value = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_prio  = '0;
      assign r_value = '0;
    end else begin : g_link_right
      assign r_valid = cell_valid[i+1];
      assign r_prio  = cell_prio[i+1];
      assign r_value = cell_value[i+1];
    end

    spq_cell #(
      .LVL_W     (LVL_W),
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .op_i         (cell_op),
      .new_prio_i   (lvl_q),
      .new_value_i  (value_q),
      .left_ins_i   (l_ins),
      .left_valid_i (l_valid),
      .left_prio_i  (l_prio),
      .left_value_i (l_value),
      .right_valid_i(r_valid),
      .right_prio_i (r_prio),
      .right_value_i(r_value),
      .ins_o        (cell_ins[i]),
      .valid_o      (cell_valid[i]),
      .prio_o       (cell_prio[i]),
      .value_o      (cell_value[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Level count table: read port A at the beat's level, port B at the front's
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] size_at_lvl;
  logic [CNT_W-1:0] size_at_front;
  logic             tbl_wr_en;
  logic [LVL_W-1:0] tbl_wr_addr;
  logic [CNT_W-1:0] tbl_wr_data;

  spq_level_table #(
    .PRIORITY_LEVELS(PRIORITY_LEVELS),
    .CNT_W          (CNT_W)
  ) u_level_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_accept),
    .rd_a_addr_i(in_lvl),
    .rd_b_addr_i(cell_prio[0]),
    .rd_a_data_o(size_at_lvl),
    .rd_b_data_o(size_at_front),
    .wr_en_i    (tbl_wr_en),
    .wr_addr_i  (tbl_wr_addr),
    .wr_data_i  (tbl_wr_data)
  );

  // ---------------------------------------------------------------------------
  // Commit: counts, row shift, table write and result
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]      total_q, total_d;
  logic [LVLS_W-1:0]     levels_q, levels_d;
  logic                  q_empty, q_full;
  logic [VALUE_BITS-1:0] res_front;
  status_e               res_status;
  logic [CNT_W-1:0]      res_lvlcnt;

  assign q_empty = !cell_valid[0];
  assign q_full  = (total_q == CNT_W'(CAPACITY));

  always_comb begin
    total_d     = total_q;
    levels_d    = levels_q;
    cell_op     = '0;
    tbl_wr_en   = 1'b0;
    tbl_wr_addr = lvl_q;
    tbl_wr_data = size_at_lvl;
    res_front   = q_empty ? '0 : cell_value[0];
    res_status  = STAT_OK;
    res_lvlcnt  = size_at_lvl;
    unique case (cmd_q)
      CMD_ENQ: begin
        if (q_full) begin
          res_status = STAT_FULL;
        end else begin
          // New entry becomes the front when it lands in cell 0
          res_front   = cell_ins[0] ? value_q : cell_value[0];
          res_lvlcnt  = size_at_lvl + CNT_W'(1);
          cell_op.enq = finish;
          tbl_wr_en   = finish;
          tbl_wr_data = size_at_lvl + CNT_W'(1);
          if (finish) begin
            total_d = total_q + CNT_W'(1);
            if (size_at_lvl == '0) levels_d = levels_q + LVLS_W'(1);
          end
        end
      end
      CMD_DEQ: begin
        if (q_empty) begin
          res_status = STAT_EMPTY;
        end else begin
          // Report the front before removal
          res_front   = cell_value[0];
          cell_op.deq = finish;
          tbl_wr_en   = finish;
          tbl_wr_addr = cell_prio[0];
          tbl_wr_data = size_at_front - CNT_W'(1);
          if (cell_prio[0] == lvl_q) res_lvlcnt = size_at_lvl - CNT_W'(1);
          if (finish) begin
            total_d = total_q - CNT_W'(1);
            if (size_at_front == CNT_W'(1)) levels_d = levels_q - LVLS_W'(1);
          end
        end
      end
      default: begin
        // Peek, and the unused code alike
        if (q_empty) res_status = STAT_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= '0;
      levels_q <= '0;
    end else begin
      total_q  <= total_d;
      levels_q <= levels_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [VALUE_W-1:0] out_front_q;
  status_e            out_status_q;
  logic [COUNT_W-1:0] out_total_q, out_levels_q, out_lvlcnt_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_front_q  <= VALUE_W'(res_front);
      out_status_q <= res_status;
      out_total_q  <= COUNT_W'(total_d);
      out_levels_q <= COUNT_W'(levels_d);
      out_lvlcnt_q <= COUNT_W'(res_lvlcnt);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - OUT_USED_W)'(0), out_lvlcnt_q, out_levels_q,
                            out_total_q, out_status_q, out_front_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_empty_matches_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q == '0) == !cell_valid[0])
    else $error("total count and head cell disagree on empty");

  a_full_matches_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q == CNT_W'(CAPACITY)) == cell_valid[CAPACITY-1])
    else $error("total count and tail cell disagree on full");

  a_levels_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(levels_q) <= 32'(total_q))
    else $error("more non-empty levels than values held");

  a_commit_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (m_axis_tvalid_o && s_axis_tready_o))
    else $error("commit did not present a result and reopen input");

endmodule
